// ===== hdl/rdsge_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsge_pkg - shared types, constants and checkword logic
// Register map, group layouts, block offsets and the CRC-10 column table used
// by the front end, the group queue and the block generator.
// ----------------------------------------------------------------------------
package rdsge_pkg;

  // Configuration register map (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_GROUP_TYPE    = 3'd0;
  localparam logic [2:0] REG_PROGRAM_ID    = 3'd1;
  localparam logic [2:0] REG_PROGRAM_TYPE  = 3'd2;
  localparam logic [2:0] REG_TRAFFIC_PROG  = 3'd3;
  localparam logic [2:0] REG_TRAFFIC_ANN   = 3'd4;
  localparam logic [2:0] REG_MUSIC_SPEECH  = 3'd5;
  localparam logic [2:0] REG_TEXT_AB       = 3'd6;
  localparam logic [2:0] REG_ALT_FREQ      = 3'd7;

  // Group type select
  localparam logic GROUP_0A = 1'b0;
  localparam logic GROUP_2A = 1'b1;

  // Group codes in block B bits 15..12
  localparam logic [3:0] GCODE_0 = 4'd0;
  localparam logic [3:0] GCODE_2 = 4'd2;

  // Block position in the group
  typedef enum logic [1:0] {
    BLK_A = 2'd0,
    BLK_B = 2'd1,
    BLK_C = 2'd2,
    BLK_D = 2'd3
  } block_idx_t;

  // Offset words per block
  localparam logic [9:0] OFFSET_A = 10'h0FC;
  localparam logic [9:0] OFFSET_B = 10'h198;
  localparam logic [9:0] OFFSET_C = 10'h168;
  localparam logic [9:0] OFFSET_D = 10'h1B4;

  // x^(i+10) mod g(x), g = x^10+x^8+x^7+x^5+x^4+x^3+1, for info bit i
  localparam logic [9:0] CRC_COL [16] = '{
    10'h1B9, 10'h372, 10'h35D, 10'h303, 10'h3BF, 10'h2C7, 10'h037, 10'h06E,
    10'h0DC, 10'h1B8, 10'h370, 10'h359, 10'h30B, 10'h3AF, 10'h2E7, 10'h077
  };

  // Configuration register file contents
  typedef struct packed {
    logic        group_type;
    logic [15:0] program_id;
    logic [4:0]  program_type;
    logic        traffic_program;
    logic        traffic_announce;
    logic        music_speech;
    logic        text_ab_flag;
    logic [15:0] alt_freq_codes;
  } cfg_t;

  // Information words of blocks B, C and D of one group
  typedef struct packed {
    logic [15:0] info_b;
    logic [15:0] info_c;
    logic [15:0] info_d;
  } group_t;

  // CRC-10 remainder of info * x^10, as a sum of constant columns
  function automatic logic [9:0] crc10(input logic [15:0] info);
    logic [9:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) begin
      if (info[i]) acc = acc ^ CRC_COL[i];
    end
    return acc;
  endfunction

endpackage

// ===== hdl/rdsge_front.sv =====
// ----------------------------------------------------------------------------
// rdsge_front - group intake
// Accepts one group's text per beat, keeps the segment counter and builds
// the information words of blocks B, C and D for the group queue.
// ----------------------------------------------------------------------------
module rdsge_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // char_a, char_b, char_c, char_d
  input  logic [0:0]            s_tuser,   // restart
  input  rdsge_pkg::cfg_t       cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output rdsge_pkg::group_t     q_group
);
  import rdsge_pkg::*;

  logic [3:0] segment;
  logic [3:0] seg_used;
  logic [7:0] char_a, char_b, char_c, char_d;
  logic       restart;

  assign char_a  = s_tdata[7:0];
  assign char_b  = s_tdata[15:8];
  assign char_c  = s_tdata[23:16];
  assign char_d  = s_tdata[31:24];
  assign restart = s_tuser[0];

  assign s_tready = ~q_full;
  assign q_push   = s_tvalid & ~q_full;

  // restart clears the address for this group already
  assign seg_used = restart ? 4'd0 : segment;

  // build block words for the selected group type
  always_comb begin
    if (cfg.group_type == GROUP_0A) begin
      q_group.info_b = {GCODE_0, 1'b0, cfg.traffic_program, cfg.program_type,
                        cfg.traffic_announce, cfg.music_speech, 1'b0, seg_used[1:0]};
      q_group.info_c = cfg.alt_freq_codes;
      q_group.info_d = {char_a, char_b};
    end else begin
      q_group.info_b = {GCODE_2, 1'b0, cfg.traffic_program, cfg.program_type,
                        cfg.text_ab_flag, seg_used};
      q_group.info_c = {char_a, char_b};
      q_group.info_d = {char_c, char_d};
    end
  end

  // segment counter, wraps at 16
  always_ff @(posedge clk) begin
    if (rst) begin
      segment <= 4'd0;
    end else if (q_push) begin
      segment <= seg_used + 4'd1;
    end
  end

endmodule

// ===== hdl/rdsge_queue.sv =====
// ----------------------------------------------------------------------------
// rdsge_queue - two-entry group queue
// Decouples group intake from block output so each side stalls on its own.
// ----------------------------------------------------------------------------
module rdsge_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rdsge_pkg::group_t     push_group,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output rdsge_pkg::group_t     head_group
);
  import rdsge_pkg::*;

  group_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_group = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_group;
  end

endmodule

// ===== hdl/rdsge_back.sv =====
// ----------------------------------------------------------------------------
// rdsge_back - block generator
// Emits the four blocks of the queue head, one per beat, each with its
// checkword, through a registered output stage.
// ----------------------------------------------------------------------------
module rdsge_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rdsge_pkg::cfg_t       cfg,
  input  logic                  head_valid,
  input  rdsge_pkg::group_t     head_group,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // info_word, check_word, zero pad
  output logic [1:0]            m_tuser,   // block_index
  output logic                  m_tlast    // last_block
);
  import rdsge_pkg::*;

  block_idx_t blk;
  logic       load;
  logic [15:0] info_sel;
  logic [9:0]  offset_sel;
  logic [15:0] info_word;
  logic [9:0]  check_word;
  block_idx_t  out_idx;

  assign load = head_valid & (~m_tvalid | m_tready);
  assign pop  = load & (blk == BLK_D);

  // word and offset of the current block
  always_comb begin
    case (blk)
      BLK_A:   begin info_sel = cfg.program_id;     offset_sel = OFFSET_A; end
      BLK_B:   begin info_sel = head_group.info_b;  offset_sel = OFFSET_B; end
      BLK_C:   begin info_sel = head_group.info_c;  offset_sel = OFFSET_C; end
      BLK_D:   begin info_sel = head_group.info_d;  offset_sel = OFFSET_D; end
      default: begin info_sel = cfg.program_id;     offset_sel = OFFSET_A; end
    endcase
  end

  // block counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      blk      <= BLK_A;
      m_tvalid <= 1'b0;
    end else if (load) begin
      blk      <= block_idx_t'(blk + 2'd1);
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      info_word  <= info_sel;
      check_word <= crc10(info_sel) ^ offset_sel;
      out_idx    <= blk;
    end
  end

  assign m_tdata = {6'd0, check_word, info_word};
  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == BLK_D);

endmodule

// ===== hdl/rds_group_encoder_top.sv =====
// ----------------------------------------------------------------------------
// rds_group_encoder_top - RDS group encoder, groups 0A and 2A
// Turns one group's text per input beat into blocks A..D with checkwords.
//
//   channel  dir  handshake                     content
//   s_*      in   s_tvalid / s_tready           group text, restart flag
//   m_*      out  m_tvalid / m_tready           one block per beat, tlast on D
//   APB      in   psel, penable, pwrite, pready configuration registers
//
// The block generator sends one block per cycle from its output register
// while a group is queued and the receiver does not stall. A two-entry queue
// holds accepted groups, so intake runs ahead while the output stalls. An
// accepted group is written into the queue, and block A then loads into the
// output register. Synchronous reset clears the registers, the segment counter,
// the queue and the output valid.
module rds_group_encoder_top (
  input  logic                            clk,
  input  logic                            rst,
  // group input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // char_a, char_b, char_c, char_d
  input  logic [0:0]                      s_tuser,  // restart
  // block output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,  // info_word, check_word, zero pad
  output logic [1:0]                      m_tuser,  // block_index
  output logic                            m_tlast,  // last_block
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdsge_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rdsge_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       q_full;
  logic       q_push;
  group_t     q_group;
  logic       q_pop;
  logic       head_valid;
  group_t     head_group;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GROUP_TYPE:   cfg.group_type       <= pwdata[0];
        REG_PROGRAM_ID:   cfg.program_id       <= pwdata[15:0];
        REG_PROGRAM_TYPE: cfg.program_type     <= pwdata[4:0];
        REG_TRAFFIC_PROG: cfg.traffic_program  <= pwdata[0];
        REG_TRAFFIC_ANN:  cfg.traffic_announce <= pwdata[0];
        REG_MUSIC_SPEECH: cfg.music_speech     <= pwdata[0];
        REG_TEXT_AB:      cfg.text_ab_flag     <= pwdata[0];
        REG_ALT_FREQ:     cfg.alt_freq_codes   <= pwdata[15:0];
        default:          cfg                  <= cfg;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_GROUP_TYPE:   prdata = {31'd0, cfg.group_type};
      REG_PROGRAM_ID:   prdata = {16'd0, cfg.program_id};
      REG_PROGRAM_TYPE: prdata = {27'd0, cfg.program_type};
      REG_TRAFFIC_PROG: prdata = {31'd0, cfg.traffic_program};
      REG_TRAFFIC_ANN:  prdata = {31'd0, cfg.traffic_announce};
      REG_MUSIC_SPEECH: prdata = {31'd0, cfg.music_speech};
      REG_TEXT_AB:      prdata = {31'd0, cfg.text_ab_flag};
      REG_ALT_FREQ:     prdata = {16'd0, cfg.alt_freq_codes};
      default:          prdata = 32'd0;
    endcase
  end

  rdsge_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_group  (q_group)
  );

  rdsge_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_group (q_group),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_group (head_group)
  );

  rdsge_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for rds_group_encoder_top
// Drives group text beats on the s_* stream and settings over APB, and
// mirrors the register file and segment counter in a bench-side encoder
// model. Every block beat on m_* is compared with the oldest predicted
// block. Directed groups cover field extremes, both group types and the
// segment wrap. Random groups then run under changing settings and idle
// patterns, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
  import rdsge_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;
  localparam logic [10:0] CRC_GEN = 11'h5B9;

  // One expected block beat
  typedef struct {
    logic [15:0] info;
    logic [9:0]  check;
    block_idx_t  idx;
    logic        last;
  } rds_block_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // char_a, char_b, char_c, char_d
  logic [0:0]  s_tuser  = '0;  // restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // info_word, check_word, zero pad
  logic [1:0]  m_tuser;        // block_index
  logic        m_tlast;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench-side mirror of the encoder
  cfg_t        shadow_cfg = '0;
  logic [3:0]  seg_addr   = '0;
  rds_block_t  block_q[$];

  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int rx_idle_pct  = 0;

  // Receiver hold-off request
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  rds_group_encoder_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // CRC-10 of info * x^10, long division, then the block offset
  function automatic logic [9:0] rds_checkword(input logic [15:0] info,
                                               input logic [9:0] offset);
    logic [25:0] rem;
    rem = {info, 10'd0};
    for (int k = 25; k >= 10; k--) begin
      if (rem[k]) rem = rem ^ ({15'd0, CRC_GEN} << (k - 10));
    end
    return rem[9:0] ^ offset;
  endfunction

  function automatic void put_expected(input logic [15:0] info, input logic [9:0] offset,
                                       input block_idx_t idx);
    rds_block_t blk;
    blk.info  = info;
    blk.check = rds_checkword(info, offset);
    blk.idx   = idx;
    blk.last  = (idx == BLK_D);
    block_q.push_back(blk);
  endfunction

  // Predict the four blocks of one accepted group beat
  function automatic void encode_group(input logic restart, input logic [31:0] text);
    logic [15:0] info_b;
    logic [15:0] info_c;
    logic [15:0] info_d;
    if (restart) seg_addr = '0;
    if (shadow_cfg.group_type == GROUP_0A) begin
      info_b = {GCODE_0, 1'b0, shadow_cfg.traffic_program, shadow_cfg.program_type,
                shadow_cfg.traffic_announce, shadow_cfg.music_speech, 1'b0, seg_addr[1:0]};
      info_c = shadow_cfg.alt_freq_codes;
      info_d = {text[7:0], text[15:8]};
    end else begin
      info_b = {GCODE_2, 1'b0, shadow_cfg.traffic_program, shadow_cfg.program_type,
                shadow_cfg.text_ab_flag, seg_addr};
      info_c = {text[7:0], text[15:8]};
      info_d = {text[23:16], text[31:24]};
    end
    put_expected(shadow_cfg.program_id, OFFSET_A, BLK_A);
    put_expected(info_b, OFFSET_B, BLK_B);
    put_expected(info_c, OFFSET_C, BLK_C);
    put_expected(info_d, OFFSET_D, BLK_D);
    seg_addr = seg_addr + 4'd1;
  endfunction

  // Compare one output beat with the oldest predicted block
  function automatic void check_block();
    rds_block_t blk;
    if (block_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("ERROR: unexpected block info=%h check=%h idx=%0d last=%0d",
                 m_tdata[15:0], m_tdata[25:16], m_tuser, m_tlast);
      return;
    end
    blk = block_q.pop_front();
    if (m_tdata[15:0] !== blk.info || m_tdata[25:16] !== blk.check ||
        m_tuser !== blk.idx || m_tlast !== blk.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("ERROR: block exp info=%h check=%h idx=%0d last=%0d, got info=%h check=%h idx=%0d last=%0d",
                 blk.info, blk.check, blk.idx, blk.last,
                 m_tdata[15:0], m_tdata[25:16], m_tuser, m_tlast);
    end
  endfunction

  // Monitor: register writes, group beats, block beats, watchdog
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg   = '0;
      seg_addr     = '0;
      quiet_cycles = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_GROUP_TYPE:   shadow_cfg.group_type       = pwdata[0];
          REG_PROGRAM_ID:   shadow_cfg.program_id       = pwdata[15:0];
          REG_PROGRAM_TYPE: shadow_cfg.program_type     = pwdata[4:0];
          REG_TRAFFIC_PROG: shadow_cfg.traffic_program  = pwdata[0];
          REG_TRAFFIC_ANN:  shadow_cfg.traffic_announce = pwdata[0];
          REG_MUSIC_SPEECH: shadow_cfg.music_speech     = pwdata[0];
          REG_TEXT_AB:      shadow_cfg.text_ab_flag     = pwdata[0];
          REG_ALT_FREQ:     shadow_cfg.alt_freq_codes   = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) encode_group(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) check_block();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One APB write; psel stays up so writes can run back to back
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Write all registers; bits above each field are filled with noise (above the group type only at random)
  task automatic apply_settings(input logic gt, input logic [15:0] pi, input logic [4:0] pty,
                                input logic tp, input logic ta, input logic ms,
                                input logic ab, input logic [15:0] af);
    reg_write(REG_GROUP_TYPE,   {$urandom_range(0, 1) ? 31'($urandom()) : 31'd0, gt});
    reg_write(REG_PROGRAM_ID,   {16'($urandom()), pi});
    reg_write(REG_PROGRAM_TYPE, {27'($urandom()), pty});
    reg_write(REG_TRAFFIC_PROG, {31'($urandom()), tp});
    reg_write(REG_TRAFFIC_ANN,  {31'($urandom()), ta});
    reg_write(REG_MUSIC_SPEECH, {31'($urandom()), ms});
    reg_write(REG_TEXT_AB,      {31'($urandom()), ab});
    reg_write(REG_ALT_FREQ,     {16'($urandom()), af});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Field value biased toward the extremes
  function automatic logic [15:0] pick_field(input int width);
    logic [15:0] ones;
    ones = 16'((17'd1 << width) - 1);
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return ones;
      default: return 16'($urandom()) & ones;
    endcase
  endfunction

  task automatic random_settings();
    apply_settings(1'(pick_field(1)), pick_field(16), 5'(pick_field(5)), 1'(pick_field(1)),
                   1'(pick_field(1)), 1'(pick_field(1)), 1'(pick_field(1)), pick_field(16));
  endtask

  // Offer one group beat and wait until it is taken
  task automatic send_group(input logic restart, input logic [7:0] ca, input logic [7:0] cb,
                            input logic [7:0] cc, input logic [7:0] cd);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = 1;
      while ($urandom_range(99) < src_idle_pct) gap++;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cd, cc, cb, ca};
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_group();
    send_group($urandom_range(0, 7) == 0, 8'($urandom()), 8'($urandom()),
               8'($urandom()), 8'($urandom()));
  endtask

  // Stop offering, wait for every predicted block, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (block_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Groups under the reset settings: 0A with all fields zero
  task automatic test_reset_defaults();
    send_group(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_group(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
  endtask

  // 0A with every field at its top, segment repeat and restart
  task automatic test_group_0a();
    apply_settings(GROUP_0A, 16'hFFFF, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF);
    send_group(1'b0, 8'hFF, 8'h00, 8'hAA, 8'h55);
    send_group(1'b0, 8'h00, 8'hFF, 8'h55, 8'hAA);
    send_group(1'b0, 8'h5A, 8'hA5, 8'hFF, 8'hFF);
    send_group(1'b0, 8'h80, 8'h01, 8'h00, 8'h00);
    send_group(1'b1, 8'h01, 8'h80, 8'h12, 8'h34);
    wait_idle();
  endtask

  // 2A: restart, then a full segment cycle and the wrap back to zero
  task automatic test_group_2a();
    apply_settings(GROUP_2A, 16'h0000, 5'd0, 1'b0, 1'b1, 1'b1, 1'b1, 16'hC3A5);
    send_group(1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00);
    for (int i = 0; i < 16; i++) begin
      send_group(1'b0, 8'(1 << (i % 8)), ~8'(1 << (i % 8)), 8'(i * 17), 8'(255 - i * 17));
    end
    wait_idle();
  endtask

  // Random groups under two random settings
  task automatic test_random_groups(input int n_items);
    for (int s = 0; s < 2; s++) begin
      random_settings();
      repeat (n_items / 2) send_random_group();
      wait_idle();
    end
  endtask

  // Output held off while groups keep coming, so the input backs up
  task automatic test_backpressure();
    random_settings();
    hold_toggle <= ~hold_toggle;
    repeat (10) send_random_group();
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 27;
    rx_idle_pct  = 49;
    test_reset_defaults();
    test_group_0a();
    test_group_2a();
    test_random_groups(44);

    src_idle_pct = 49;
    rx_idle_pct  = 27;
    test_random_groups(44);

    src_idle_pct = 0;
    rx_idle_pct  = 0;
    test_random_groups(44);
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && block_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
